>>> rtl/core/veg_pkg.sv
// Shared widths, register indexes, reset values and small helpers for the
// voice envelope gate and normalizer. No dependencies.
package veg_pkg;

    localparam int ENV_W   = 16;
    localparam int ALPHA_W = ENV_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ALPHA_W;

    localparam logic [ALPHA_W-1:0] UNIT_ONE = {1'b1, {ENV_W{1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GATE_BAND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_MARGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_RISE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_FALL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_ATTACK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_RELEASE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEVEL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LEVEL  = 3'd7;

    // Register values after reset.
    localparam logic [ENV_W-1:0]   GATE_BAND_RST    = 16'd2048;
    localparam logic [ENV_W-1:0]   GATE_MARGIN_RST  = 16'd1024;
    localparam logic [ALPHA_W-1:0] FLOOR_RISE_RST   = 17'd655;
    localparam logic [ALPHA_W-1:0] FLOOR_FALL_RST   = 17'd6554;
    localparam logic [ALPHA_W-1:0] PEAK_ATTACK_RST  = 17'd19661;
    localparam logic [ALPHA_W-1:0] PEAK_RELEASE_RST = 17'd655;
    localparam logic [ALPHA_W-1:0] OPEN_LEVEL_RST   = 17'd19661;
    localparam logic [ALPHA_W-1:0] CLOSE_LEVEL_RST  = 17'd9830;

    // Default tracking bounds.
    localparam logic [ENV_W-1:0] FLOOR_MIN_DEF = 16'd64;
    localparam logic [ENV_W-1:0] FLOOR_MAX_DEF = 16'd16384;
    localparam logic [ENV_W-1:0] PEAK_MIN_DEF  = 16'd1024;
    localparam logic [ENV_W-1:0] PEAK_MAX_DEF  = 16'd65535;

    // Handshake status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Below the minimum gives the minimum, otherwise above the maximum gives the maximum.
    function automatic logic [ENV_W-1:0] clamp_env(
        input logic [ENV_W-1:0] v,
        input logic [ENV_W-1:0] lo,
        input logic [ENV_W-1:0] hi
    );
        logic [ENV_W-1:0] r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // A weight above one acts as one.
    function automatic logic [ALPHA_W-1:0] sat_alpha(input logic [ALPHA_W-1:0] a);
        return (a > UNIT_ONE) ? UNIT_ONE : a;
    endfunction

endpackage

>>> rtl/core/veg_serial_mul.sv
// Bit-serial shift-add multiplier giving the rounded step of an average,
// (alpha * mag + half) >> ENV_W. Depends on veg_pkg.
module veg_serial_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [veg_pkg::ALPHA_W-1:0]  alpha,
    input  logic [veg_pkg::ENV_W-1:0]    mag,
    output logic [veg_pkg::ENV_W-1:0]    step,
    output veg_pkg::unit_stat_t          stat
);
    import veg_pkg::*;

    localparam int CNT_W = $clog2(ENV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ENV_W - 1);

    logic [ALPHA_W-1:0] alpha_reg;
    logic [ENV_W-1:0]   mag_reg;
    logic [ALPHA_W-1:0] hi_reg;
    logic [ENV_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [ALPHA_W:0]   sum;
    logic [ALPHA_W-1:0] rounded;

    // One multiplier bit per cycle: add the weight into the upper half, then shift right.
    assign sum     = {1'b0, hi_reg} + (mag_reg[0] ? {1'b0, alpha_reg} : '0);
    assign rounded = hi_reg + ALPHA_W'(lo_reg[ENV_W-1]);
    assign step    = rounded[ENV_W-1:0];
    assign stat    = '{busy: busy_reg, done: done_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            alpha_reg <= alpha;
            mag_reg   <= mag;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else if (busy_reg)
        begin
            hi_reg  <= sum[ALPHA_W:1];
            lo_reg  <= {sum[0], lo_reg[ENV_W-1:1]};
            mag_reg <= mag_reg >> 1;
        end
    end

endmodule

>>> rtl/core/veg_serial_div.sv
// Restoring divider, one quotient bit per cycle, for (speech << ENV_W) / peak
// saturated to one. Depends on veg_pkg.
module veg_serial_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [veg_pkg::ENV_W-1:0]    dividend,
    input  logic [veg_pkg::ENV_W-1:0]    divisor,
    output logic [veg_pkg::ALPHA_W-1:0]  quotient,
    output veg_pkg::unit_stat_t          stat
);
    import veg_pkg::*;

    localparam int CNT_W = $clog2(ENV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ENV_W - 1);

    logic [ENV_W-1:0] dvd_reg;
    logic [ENV_W-1:0] dsr_reg;
    logic [ENV_W-1:0] rem_reg;
    logic [ENV_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [ENV_W:0]   shifted;
    logic [ENV_W:0]   diff;
    logic             fits;
    logic             sat;
    logic             zero;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    // A dividend at or above the divisor means a ratio of one or more.
    assign zero     = (dsr_reg == '0);
    assign sat      = (dvd_reg >= dsr_reg);
    assign quotient = zero ? '0 : (sat ? UNIT_ONE : {1'b0, quo_reg});
    assign stat     = '{busy: busy_reg, done: done_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= dividend;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[ENV_W-1:0] : shifted[ENV_W-1:0];
            quo_reg <= {quo_reg[ENV_W-2:0], fits};
        end
    end

endmodule

>>> rtl/core/voice_envelope_gate_normalizer.sv
// Top level of the voice envelope gate and normalizer: sequencer, state and
// configuration registers. Depends on veg_pkg, veg_serial_mul and veg_serial_div.
//
// Usage. Each item on the block channel (block_valid, block_ready,
// block_envelope) is the envelope of one audio block, unsigned Q0.16. For every
// item exactly one item leaves on the result channel (result_valid,
// result_ready): normalized_level (65536 is 1.0), speech_level, floor_level and
// mouth_is_open. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data) that takes one register per clock, to be used while the block idles.
// Timing. The block works on one item at a time: a new item is accepted only
// once the last one has been loaded into the output register. The two averaging
// steps run on one bit-serial multiplier and the ratio on a bit-serial divider;
// the floor step is skipped while the noise floor is frozen.
// Stalls. The result sits in an output register; the next item is accepted and
// computed while that result still waits, and only the final load waits for it.
// Reset. Asynchronous, active low: registers go to their defaults, the floor to
// FLOOR_MIN, the peak reference to PEAK_MIN and the mouth closed.
module voice_envelope_gate_normalizer #(
    parameter logic [veg_pkg::ENV_W-1:0] FLOOR_MIN = veg_pkg::FLOOR_MIN_DEF,
    parameter logic [veg_pkg::ENV_W-1:0] FLOOR_MAX = veg_pkg::FLOOR_MAX_DEF,
    parameter logic [veg_pkg::ENV_W-1:0] PEAK_MIN  = veg_pkg::PEAK_MIN_DEF,
    parameter logic [veg_pkg::ENV_W-1:0] PEAK_MAX  = veg_pkg::PEAK_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            block_valid,
    output logic                            block_ready,
    input  logic [veg_pkg::ENV_W-1:0]       block_envelope,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [veg_pkg::ALPHA_W-1:0]     normalized_level,
    output logic [veg_pkg::ENV_W-1:0]       speech_level,
    output logic [veg_pkg::ENV_W-1:0]       floor_level,
    output logic                            mouth_is_open,
    input  logic                            cfg_we,
    input  logic [veg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [veg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import veg_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FLOOR  = 3'd1;
    localparam logic [2:0] ST_FMUL   = 3'd2;
    localparam logic [2:0] ST_SPEECH = 3'd3;
    localparam logic [2:0] ST_PEAK   = 3'd4;
    localparam logic [2:0] ST_PMUL   = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    // Configuration registers.
    logic [ENV_W-1:0]   gate_band_reg;
    logic [ENV_W-1:0]   gate_margin_reg;
    logic [ALPHA_W-1:0] floor_rise_reg;
    logic [ALPHA_W-1:0] floor_fall_reg;
    logic [ALPHA_W-1:0] peak_attack_reg;
    logic [ALPHA_W-1:0] peak_release_reg;
    logic [ALPHA_W-1:0] open_level_reg;
    logic [ALPHA_W-1:0] close_level_reg;

    // Tracking state and sequencer.
    logic [2:0]         state_reg, state_next;
    logic [ENV_W-1:0]   floor_reg, floor_next;
    logic [ENV_W-1:0]   peak_reg, peak_next;
    logic               mouth_reg, mouth_next;

    // Per-item working registers.
    logic [ENV_W-1:0]   env_reg;
    logic [ENV_W-1:0]   speech_reg, speech_next;
    logic               up_reg, up_next;
    logic [ALPHA_W-1:0] norm_reg, norm_next;

    // Output register.
    logic               res_valid_reg;
    logic [ALPHA_W-1:0] res_norm_reg;
    logic [ENV_W-1:0]   res_speech_reg;
    logic [ENV_W-1:0]   res_floor_reg;
    logic               res_mouth_reg;
    logic               res_load;

    // Datapath.
    logic [ENV_W:0]     band_sum;
    logic [ENV_W:0]     margin_sum;
    logic               frozen;
    logic [ENV_W-1:0]   target;
    logic [ENV_W-1:0]   ema_cur;
    logic [ENV_W-1:0]   ema_tgt;
    logic               ema_ge;
    logic [ENV_W-1:0]   ema_mag;
    logic [ENV_W-1:0]   moved_cur;
    logic [ENV_W-1:0]   moved;
    logic               mul_start;
    logic [ALPHA_W-1:0] mul_alpha;
    logic [ENV_W-1:0]   mul_step;
    unit_stat_t         mul_stat;
    logic               div_start;
    logic [ALPHA_W-1:0] div_quot;
    unit_stat_t         div_stat;

    veg_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .alpha (mul_alpha),
        .mag   (ema_mag),
        .step  (mul_step),
        .stat  (mul_stat)
    );

    veg_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (speech_reg),
        .divisor  (peak_next),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign block_ready      = (state_reg == ST_IDLE);
    assign result_valid     = res_valid_reg;
    assign normalized_level = res_norm_reg;
    assign speech_level     = res_speech_reg;
    assign floor_level      = res_floor_reg;
    assign mouth_is_open    = res_mouth_reg;

    // The floor freezes while the envelope stands more than the band above it.
    assign band_sum   = {1'b0, floor_reg} + {1'b0, gate_band_reg};
    assign frozen     = ({1'b0, env_reg} > band_sum);
    assign margin_sum = {1'b0, floor_reg} + {1'b0, gate_margin_reg};
    assign target     = (speech_reg > PEAK_MIN) ? speech_reg : PEAK_MIN;

    // One averaging step is shared by the floor and the peak reference: the
    // magnitude of the gap feeds the multiplier and the rounded step is then
    // added toward the target.
    assign ema_cur   = (state_reg == ST_PEAK) ? peak_reg : floor_reg;
    assign ema_tgt   = (state_reg == ST_PEAK) ? target : env_reg;
    assign ema_ge    = (ema_tgt >= ema_cur);
    assign ema_mag   = ema_ge ? (ema_tgt - ema_cur) : (ema_cur - ema_tgt);
    assign moved_cur = (state_reg == ST_PMUL) ? peak_reg : floor_reg;
    assign moved     = up_reg ? (moved_cur + mul_step) : (moved_cur - mul_step);

    always_comb
    begin
        if (state_reg == ST_PEAK)
            mul_alpha = sat_alpha((target > peak_reg) ? peak_attack_reg : peak_release_reg);
        else
            mul_alpha = sat_alpha(ema_ge ? floor_rise_reg : floor_fall_reg);
    end

    assign res_load = (state_reg == ST_OUT) && (!res_valid_reg || result_ready);

    always_comb
    begin
        state_next  = state_reg;
        floor_next  = floor_reg;
        peak_next   = peak_reg;
        mouth_next  = mouth_reg;
        speech_next = speech_reg;
        up_next     = up_reg;
        norm_next   = norm_reg;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (block_valid)
                    state_next = ST_FLOOR;
            end
            ST_FLOOR:
            begin
                if (frozen)
                begin
                    floor_next = clamp_env(floor_reg, FLOOR_MIN, FLOOR_MAX);
                    state_next = ST_SPEECH;
                end
                else
                begin
                    mul_start  = 1'b1;
                    up_next    = ema_ge;
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL:
            begin
                if (mul_stat.done)
                begin
                    floor_next = clamp_env(moved, FLOOR_MIN, FLOOR_MAX);
                    state_next = ST_SPEECH;
                end
            end
            ST_SPEECH:
            begin
                // Speech is what the envelope holds above floor plus margin.
                if ({1'b0, env_reg} > margin_sum)
                    speech_next = ENV_W'({1'b0, env_reg} - margin_sum);
                else
                    speech_next = '0;
                state_next = ST_PEAK;
            end
            ST_PEAK:
            begin
                mul_start  = 1'b1;
                up_next    = ema_ge;
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                // The divider takes the clamped peak straight from here.
                peak_next = clamp_env(moved, PEAK_MIN, PEAK_MAX);
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    peak_next = peak_reg;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    norm_next  = div_quot;
                    mouth_next = mouth_reg ? (div_quot >= close_level_reg)
                                           : (div_quot >= open_level_reg);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            floor_reg     <= FLOOR_MIN;
            peak_reg      <= PEAK_MIN;
            mouth_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            floor_reg <= floor_next;
            peak_reg  <= peak_next;
            mouth_reg <= mouth_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (block_valid && block_ready)
            env_reg <= block_envelope;
        speech_reg <= speech_next;
        up_reg     <= up_next;
        norm_reg   <= norm_next;
        if (res_load)
        begin
            res_norm_reg   <= norm_reg;
            res_speech_reg <= speech_reg;
            res_floor_reg  <= floor_reg;
            res_mouth_reg  <= mouth_reg;
        end
    end

    // Configuration writes; 16-bit registers keep the low bits of the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_band_reg    <= GATE_BAND_RST;
            gate_margin_reg  <= GATE_MARGIN_RST;
            floor_rise_reg   <= FLOOR_RISE_RST;
            floor_fall_reg   <= FLOOR_FALL_RST;
            peak_attack_reg  <= PEAK_ATTACK_RST;
            peak_release_reg <= PEAK_RELEASE_RST;
            open_level_reg   <= OPEN_LEVEL_RST;
            close_level_reg  <= CLOSE_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GATE_BAND:    gate_band_reg    <= cfg_data[ENV_W-1:0];
                REG_GATE_MARGIN:  gate_margin_reg  <= cfg_data[ENV_W-1:0];
                REG_FLOOR_RISE:   floor_rise_reg   <= cfg_data;
                REG_FLOOR_FALL:   floor_fall_reg   <= cfg_data;
                REG_PEAK_ATTACK:  peak_attack_reg  <= cfg_data;
                REG_PEAK_RELEASE: peak_release_reg <= cfg_data;
                REG_OPEN_LEVEL:   open_level_reg   <= cfg_data;
                REG_CLOSE_LEVEL:  close_level_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The multiplier and the divider are never in use together.
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy at once");

    // The ratio saturates at one.
    a_norm_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (normalized_level <= UNIT_ONE))
        else $error("normalized level above one");

    // With ordered bounds the reported floor lies inside them.
    a_floor_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((FLOOR_MIN > FLOOR_MAX) ||
                          ((floor_level >= FLOOR_MIN) && (floor_level <= FLOOR_MAX))))
        else $error("floor level outside its bounds");

    // With ordered bounds the peak reference never drops below its minimum.
    a_peak_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (PEAK_MIN > PEAK_MAX) || (peak_reg >= PEAK_MIN))
        else $error("peak reference below its minimum");

endmodule
